// ----- design/ncc_pkg.sv -----
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants of the n-chance clock page replacer.
// ----------------------------------------------------------------------------
package ncc_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int PAGE_BITS_DEF = 20;

	localparam int COUNT_W   = 5;
	localparam int LIMIT_W   = 5;
	localparam int CAP_W     = 7;
	localparam int CFG_W     = 7;
	localparam int CAP_RESET = 64;
	localparam int LIMIT_RESET = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic CFG_SWEEP_LIMIT  = 1'b0;
	localparam logic CFG_SET_CAPACITY = 1'b1;

	localparam logic ACT_FAULT = 1'b0;
	localparam logic ACT_REF   = 1'b1;

	typedef struct packed {
		logic               used;
		logic               modified;
		logic [COUNT_W-1:0] count;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// A freshly loaded page is used, clean and has swept zero times.
	localparam meta_t META_NEW = '{used: 1'b1, modified: 1'b0, count: '0};

	typedef struct packed {
		logic [COUNT_W-1:0] lim;
		logic               neg;
	} limit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REF,
		ST_SWEEP
	} state_t;

endpackage

// ----- design/ncc_sweep_unit.sv -----
// ----------------------------------------------------------------------------
// ncc_sweep_unit
// One clock-hand step: ages or clears the slot under the hand and decides
// whether it is the victim.
// ----------------------------------------------------------------------------
module ncc_sweep_unit
	import ncc_pkg::*;
(
	input  meta_t  entry,
	input  limit_t limit,
	output meta_t  entry_next,
	output logic   victim
);

	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] need;

	always_comb begin
		count_inc = (entry.count < COUNT_MAX) ? entry.count + 1'b1 : entry.count;
		need      = limit.lim + COUNT_W'(limit.neg & entry.modified);
		entry_next = entry;
		victim     = 1'b0;
		if (entry.used) begin
			entry_next.used  = 1'b0;
			entry_next.count = '0;
		end else begin
			entry_next.count = count_inc;
			victim           = (count_inc >= need);
		end
	end

endmodule

// ----- design/nchance_clock_page_replacer_core.sv -----
// ----------------------------------------------------------------------------
// nchance_clock_page_replacer_core
// Working-set page replacer with an n-chance clock sweep over a slot ring.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (in_valid / in_stall) and carry an
// action: a page fault for page, or a reference to ref_slot. A reference
// updates the used and modified bits of its slot and produces no result; it
// keeps the block busy through the REF state. A fault produces exactly one
// result item on the output channel (out_valid / out_stall).
// While the working set is below its capacity, a fault places the page in
// the next free slot and its result is visible on the cycle after it is
// accepted. Once the set is full, the clock hand walks the ring one slot per
// cycle through a single read-modify-write port of the slot memory. The number
// k of slots the hand visits for a fault is at most (need + 1) * fill_count,
// need being the magnitude of the sweep limit, plus one for a modified page
// under a negative limit.
// The result sits in an output register. In the idle state a new item is
// taken while that register is empty or is being drained in the same cycle;
// when the receiver stalls with a result pending, the input channel stalls too.
// Reset clears the fill count, the hand and the handshake state and loads
// the register defaults (limit 1, capacity 64). The slot memory is not
// cleared: only slots below the fill count are ever used, and placement has
// written each of them. Registers must be written only while the block is idle.
// ----------------------------------------------------------------------------
module nchance_clock_page_replacer_core
	import ncc_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	localparam int SLOT_W   = $clog2(SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [SLOT_W-1:0]    ref_slot,
	input  logic                 ref_write,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_W-1:0]    slot,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] victim_page,
	output logic                 victim_dirty
);

	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int WORD_W = PAGE_BITS + META_W;

	// Configuration registers.
	logic [LIMIT_W-1:0] sweep_limit_q;
	logic [CAP_W-1:0]   set_capacity_q;

	// Control state.
	state_t              state_q, state_d;
	logic [FILL_W-1:0]   fill_count_q;
	logic [SLOT_W-1:0]   hand_q;
	logic                out_valid_q;
	logic                byp_q;

	// Item registers.
	logic [PAGE_BITS-1:0] page_q;
	logic [SLOT_W-1:0]    ref_slot_q;
	logic                 ref_write_q;
	logic                 ref_ok_q;

	// Slot memory: page number plus replacement metadata per slot.
	logic [WORD_W-1:0] mem [SLOTS];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] byp_data_q;

	// Memory port controls.
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic              we;
	logic [SLOT_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// Result load.
	logic                 out_load;
	logic [SLOT_W-1:0]    res_slot;
	logic                 res_evicted;
	logic [PAGE_BITS-1:0] res_page;
	logic                 res_dirty;

	logic                 accept;
	logic [CMP_W-1:0]     cap_eff;
	logic                 set_full;
	logic                 fill_done;
	logic                 ref_ok;
	logic [SLOT_W-1:0]    hand_start;
	logic [SLOT_W-1:0]    hand_next;
	limit_t               limit;

	logic [WORD_W-1:0]    entry_word;
	meta_t                entry_meta;
	logic [PAGE_BITS-1:0] entry_page;
	meta_t                meta_next;
	meta_t                meta_ref;
	logic                 victim;

	// Effective capacity: zero acts as one, anything above the ring size as
	// the ring size.
	always_comb begin
		cap_eff = CMP_W'(set_capacity_q);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end
		if (cap_eff > CMP_W'(SLOTS)) begin
			cap_eff = CMP_W'(SLOTS);
		end
	end

	assign set_full  = (CMP_W'(fill_count_q) >= cap_eff);
	assign fill_done = (CMP_W'(fill_count_q) + CMP_W'(1) >= cap_eff);
	assign ref_ok    = (FILL_W'(ref_slot) < fill_count_q);

	// The hand restarts at slot zero if it sits outside the held ring.
	assign hand_start = (FILL_W'(hand_q) >= fill_count_q) ? '0 : hand_q;
	assign hand_next  = (FILL_W'(hand_q) + FILL_W'(1) >= fill_count_q) ?
		'0 : SLOT_W'(FILL_W'(hand_q) + FILL_W'(1));

	// Sweep limit magnitude. A negative limit gives modified pages one
	// more sweep; a limit of zero behaves as plus one.
	always_comb begin
		limit.neg = sweep_limit_q[LIMIT_W-1];
		limit.lim = limit.neg ? COUNT_W'(-sweep_limit_q) :
			COUNT_W'(sweep_limit_q[LIMIT_W-2:0]);
		if (limit.lim == '0) begin
			limit.lim = COUNT_W'(1);
			limit.neg = 1'b0;
		end
	end

	// Read data, forwarded when the previous cycle wrote the slot it read.
	assign entry_word = byp_q ? byp_data_q : rd_q;
	assign entry_meta = meta_t'(entry_word[META_W-1:0]);
	assign entry_page = entry_word[WORD_W-1:META_W];

	always_comb begin
		meta_ref          = entry_meta;
		meta_ref.used     = 1'b1;
		meta_ref.modified = entry_meta.modified | ref_write_q;
	end

	ncc_sweep_unit u_sweep (
		.entry      (entry_meta),
		.limit      (limit),
		.entry_next (meta_next),
		.victim     (victim)
	);

	assign accept = in_valid && !in_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_REF) begin
					state_d = ST_REF;
				end else if (accept && set_full) begin
					state_d = ST_SWEEP;
				end
			end
			ST_REF: begin
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (victim) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall    = 1'b1;
		rd_en       = 1'b0;
		rd_addr     = hand_q;
		we          = 1'b0;
		wr_addr     = hand_q;
		wr_data     = {entry_page, meta_next};
		out_load    = 1'b0;
		res_slot    = hand_q;
		res_evicted = 1'b0;
		res_page    = '0;
		res_dirty   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				if (accept && action == ACT_REF) begin
					rd_en   = 1'b1;
					rd_addr = ref_slot;
				end else if (accept && !set_full) begin
					// Placement into the next free slot.
					we       = 1'b1;
					wr_addr  = fill_count_q[SLOT_W-1:0];
					wr_data  = {page, META_NEW};
					out_load = 1'b1;
					res_slot = fill_count_q[SLOT_W-1:0];
				end else if (accept) begin
					rd_en   = 1'b1;
					rd_addr = hand_start;
				end
			end
			ST_REF: begin
				we      = ref_ok_q;
				wr_addr = ref_slot_q;
				wr_data = {entry_page, meta_ref};
			end
			ST_SWEEP: begin
				we = 1'b1;
				if (victim) begin
					wr_data     = {page_q, META_NEW};
					out_load    = 1'b1;
					res_evicted = 1'b1;
					res_page    = entry_page;
					res_dirty   = entry_meta.modified;
				end else begin
					rd_en   = 1'b1;
					rd_addr = hand_next;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Slot memory with registered read and same-cycle forwarding flag.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= we && (wr_addr == rd_addr);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_limit_q  <= LIMIT_W'(LIMIT_RESET);
			set_capacity_q <= CAP_W'(CAP_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SWEEP_LIMIT:  sweep_limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_SET_CAPACITY: set_capacity_q <= cfg_data[CAP_W-1:0];
				default:          sweep_limit_q  <= sweep_limit_q;
			endcase
		end
	end

	// Control state: sequencer, fill count, hand and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_count_q <= '0;
			hand_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && action == ACT_FAULT) begin
				if (!set_full) begin
					fill_count_q <= fill_count_q + FILL_W'(1);
					if (fill_done) begin
						hand_q <= '0;
					end
				end else begin
					hand_q <= hand_start;
				end
			end else if (state_q == ST_SWEEP) begin
				hand_q <= hand_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q      <= page;
			ref_slot_q  <= ref_slot;
			ref_write_q <= ref_write;
			ref_ok_q    <= ref_ok;
		end
		if (out_load) begin
			slot         <= res_slot;
			evicted      <= res_evicted;
			victim_page  <= res_page;
			victim_dirty <= res_dirty;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// The set never holds more pages than the ring has slots.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FILL_W'(SLOTS))
		else $error("fill count beyond ring size");

	// While sweeping, the hand stays inside the held ring.
	a_hand_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> FILL_W'(hand_q) < fill_count_q)
		else $error("hand outside the held ring");

	// A new result never overwrites one the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");

	// A reference finishes its update in the cycle after it is accepted.
	a_ref_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REF |=> state_q == ST_IDLE)
		else $error("reference update did not complete");
`endif

endmodule
